@@ rtl/core/rksa_pkg.sv @@
package rksa_pkg;

  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned TEMP_W  = 10;
  localparam int unsigned POWER_W = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 8;

  localparam logic [IDX_W-1:0] REG_PRESCALE_LIMIT = 8'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_MIN       = 8'd1;
  localparam logic [IDX_W-1:0] REG_TEMP_MAX       = 8'd2;
  localparam logic [IDX_W-1:0] REG_POWER_MAX      = 8'd3;

  localparam logic [LIMIT_W-1:0] RST_PRESCALE_LIMIT = 16'd400;
  localparam logic [TEMP_W-1:0]  RST_TEMP_MIN       = 10'd84;
  localparam logic [TEMP_W-1:0]  RST_TEMP_MAX       = 10'd424;
  localparam logic [POWER_W-1:0] RST_POWER_MAX      = 8'd100;
  localparam logic [TEMP_W-1:0]  RST_TEMP_SETTING   = 10'd84;

  localparam logic [2:0] MODE_TEMP_SINGLE  = 3'd1;
  localparam logic [2:0] MODE_TEMP_DUAL    = 3'd2;
  localparam logic [2:0] MODE_POWER_SINGLE = 3'd3;
  localparam logic [2:0] MODE_POWER_DUAL   = 3'd4;

  localparam logic [1:0] DIR_HOLD  = 2'd0;
  localparam logic [1:0] DIR_PLUS  = 2'd1;
  localparam logic [1:0] DIR_MINUS = 2'd2;

  typedef struct packed {
    logic [LIMIT_W-1:0] prescale_limit;
    logic [TEMP_W-1:0]  temp_min;
    logic [TEMP_W-1:0]  temp_max;
    logic [POWER_W-1:0] power_max;
  } cfg_t;

  typedef struct packed {
    logic       a_level;
    logic       b_level;
    logic [2:0] screen_mode;
    logic       temp_channel;
    logic       power_channel;
    logic       temp_lock_ch0;
    logic       temp_lock_ch1;
    logic       power_lock_ch0;
    logic       power_lock_ch1;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_out_ch0;
    logic [TEMP_W-1:0]  temp_out_ch1;
    logic [POWER_W-1:0] power_out_ch0;
    logic [POWER_W-1:0] power_out_ch1;
    logic               acted;
    logic [1:0]         step_dir;
  } result_t;

endpackage

@@ rtl/core/rksa_cfg_regs.sv @@
module rksa_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rksa_pkg::IDX_W-1:0]      cfg_index,
  input  logic [rksa_pkg::CFG_W-1:0]      cfg_data,
  output rksa_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_limit <= rksa_pkg::RST_PRESCALE_LIMIT;
      cfg.temp_min       <= rksa_pkg::RST_TEMP_MIN;
      cfg.temp_max       <= rksa_pkg::RST_TEMP_MAX;
      cfg.power_max      <= rksa_pkg::RST_POWER_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rksa_pkg::REG_PRESCALE_LIMIT: cfg.prescale_limit <= cfg_data;
        rksa_pkg::REG_TEMP_MIN:       cfg.temp_min  <= cfg_data[rksa_pkg::TEMP_W-1:0];
        rksa_pkg::REG_TEMP_MAX:       cfg.temp_max  <= cfg_data[rksa_pkg::TEMP_W-1:0];
        rksa_pkg::REG_POWER_MAX:      cfg.power_max <= cfg_data[rksa_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/rksa_adjust.sv @@
module rksa_adjust (
  input  logic              clk,
  input  logic              rst,
  input  rksa_pkg::cfg_t    cfg,
  input  logic              go,
  input  rksa_pkg::item_t   item,
  output rksa_pkg::result_t res
);

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_TEMP,
    SEL_POWER
  } sel_t;

  logic [rksa_pkg::LIMIT_W-1:0] tick_counter;
  logic [rksa_pkg::LIMIT_W-1:0] tick_counter_next;
  logic                         prev_a;
  logic                         prev_a_next;
  logic [rksa_pkg::TEMP_W-1:0]  temp_setting [2];
  logic [rksa_pkg::POWER_W-1:0] power_setting [2];
  logic [rksa_pkg::TEMP_W-1:0]  temp_cur;
  logic [rksa_pkg::TEMP_W-1:0]  temp_next;
  logic [rksa_pkg::POWER_W-1:0] power_cur;
  logic [rksa_pkg::POWER_W-1:0] power_next;
  logic                         acted;
  logic                         acted_next;
  logic [1:0]                   step_dir;
  logic [1:0]                   dir_next;
  sel_t                         sel;
  logic                         ch;

  always_comb begin
    sel = SEL_NONE;
    ch  = 1'b0;
    if (!item.temp_lock_ch0 && item.screen_mode == rksa_pkg::MODE_TEMP_SINGLE) begin
      sel = SEL_TEMP;
    end else if (!item.temp_lock_ch0 && item.screen_mode == rksa_pkg::MODE_TEMP_DUAL &&
                 !item.temp_channel) begin
      sel = SEL_TEMP;
    end else if (!item.temp_lock_ch1 && item.screen_mode == rksa_pkg::MODE_TEMP_DUAL &&
                 item.temp_channel) begin
      sel = SEL_TEMP;
      ch  = 1'b1;
    end else if (!item.power_lock_ch0 &&
                 item.screen_mode == rksa_pkg::MODE_POWER_SINGLE) begin
      sel = SEL_POWER;
    end else if (!item.power_lock_ch0 && item.screen_mode == rksa_pkg::MODE_POWER_DUAL &&
                 !item.power_channel) begin
      sel = SEL_POWER;
    end else if (!item.power_lock_ch1 && item.screen_mode == rksa_pkg::MODE_POWER_DUAL &&
                 item.power_channel) begin
      sel = SEL_POWER;
      ch  = 1'b1;
    end
  end

  always_comb begin
    acted_next        = 1'b0;
    dir_next          = rksa_pkg::DIR_HOLD;
    prev_a_next       = prev_a;
    tick_counter_next = tick_counter + 1'b1;
    if (tick_counter >= cfg.prescale_limit) begin
      tick_counter_next = '0;
      acted_next        = 1'b1;
      if (sel != SEL_NONE && item.a_level != prev_a) begin
        prev_a_next = item.a_level;
        dir_next    = (item.b_level != item.a_level) ? rksa_pkg::DIR_MINUS
                                                     : rksa_pkg::DIR_PLUS;
      end
    end
  end

  always_comb begin
    temp_cur   = temp_setting[ch];
    power_cur  = power_setting[ch];
    temp_next  = temp_cur;
    power_next = power_cur;
    if (dir_next == rksa_pkg::DIR_MINUS && temp_cur > cfg.temp_min) begin
      temp_next = temp_cur - 1'b1;
    end else if (dir_next == rksa_pkg::DIR_PLUS && temp_cur < cfg.temp_max) begin
      temp_next = temp_cur + 1'b1;
    end
    if (dir_next == rksa_pkg::DIR_MINUS && power_cur != '0) begin
      power_next = power_cur - 1'b1;
    end else if (dir_next == rksa_pkg::DIR_PLUS && power_cur < cfg.power_max) begin
      power_next = power_cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter     <= '0;
      prev_a           <= 1'b0;
      temp_setting[0]  <= rksa_pkg::RST_TEMP_SETTING;
      temp_setting[1]  <= rksa_pkg::RST_TEMP_SETTING;
      power_setting[0] <= '0;
      power_setting[1] <= '0;
      acted            <= 1'b0;
      step_dir         <= rksa_pkg::DIR_HOLD;
    end else if (go) begin
      tick_counter <= tick_counter_next;
      prev_a       <= prev_a_next;
      acted        <= acted_next;
      step_dir     <= dir_next;
      if (sel == SEL_TEMP && acted_next) begin
        temp_setting[ch] <= temp_next;
      end
      if (sel == SEL_POWER && acted_next) begin
        power_setting[ch] <= power_next;
      end
    end
  end

  assign res.temp_out_ch0  = temp_setting[0];
  assign res.temp_out_ch1  = temp_setting[1];
  assign res.power_out_ch0 = power_setting[0];
  assign res.power_out_ch1 = power_setting[1];
  assign res.acted         = acted;
  assign res.step_dir      = step_dir;

endmodule

@@ rtl/core/rotary_knob_setpoint_adjust.sv @@
// Rotary knob setpoint adjuster with quadrature decoding.
// Input channel (in_valid/in_stall): one transaction per tick, carrying the
// sampled encoder pins, screen mode, active channels and lock flags.
// Output channel (out_valid/out_stall): one transaction per input tick with
// all four setpoints after the tick, the prescaler acting flag and the step.
// Config port: cfg_we writes cfg_data to register cfg_index (0 prescale
// limit, 1 temp min, 2 temp max, 3 power max); other indexes are ignored.
// Flow: a tick is captured in the input register, then the setpoint state
// and result register are updated once the output can advance; the result is
// presented from those registers. Throughput: one tick per cycle while out_stall
// is low, set by the single compare and saturating step on the setpoint state.
// Reset clears both pipeline stages, the tick counter and previous A, loads
// the register defaults and sets temperatures to 84 and powers to 0.
// While out_stall is high the result holds; one more tick is taken into the
// input register if it is empty, after which in_stall rises until the result is taken.
module rotary_knob_setpoint_adjust (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             a_level,
  input  logic                             b_level,
  input  logic [2:0]                       screen_mode,
  input  logic                             temp_channel,
  input  logic                             power_channel,
  input  logic                             temp_lock_ch0,
  input  logic                             temp_lock_ch1,
  input  logic                             power_lock_ch0,
  input  logic                             power_lock_ch1,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rksa_pkg::TEMP_W-1:0]      temp_out_ch0,
  output logic [rksa_pkg::TEMP_W-1:0]      temp_out_ch1,
  output logic [rksa_pkg::POWER_W-1:0]     power_out_ch0,
  output logic [rksa_pkg::POWER_W-1:0]     power_out_ch1,
  output logic                             acted,
  output logic [1:0]                       step_dir,
  input  logic                             cfg_we,
  input  logic [rksa_pkg::IDX_W-1:0]       cfg_index,
  input  logic [rksa_pkg::CFG_W-1:0]       cfg_data
);

  rksa_pkg::cfg_t    cfg;
  rksa_pkg::item_t   item;
  rksa_pkg::result_t res;
  logic              item_valid;
  logic              advance;
  logic              go;

  assign advance  = !out_valid || !out_stall;
  assign go       = item_valid && advance;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        item_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.a_level        <= a_level;
      item.b_level        <= b_level;
      item.screen_mode    <= screen_mode;
      item.temp_channel   <= temp_channel;
      item.power_channel  <= power_channel;
      item.temp_lock_ch0  <= temp_lock_ch0;
      item.temp_lock_ch1  <= temp_lock_ch1;
      item.power_lock_ch0 <= power_lock_ch0;
      item.power_lock_ch1 <= power_lock_ch1;
    end
  end

  rksa_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rksa_adjust u_adjust (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .go   (go),
    .item (item),
    .res  (res)
  );

  assign temp_out_ch0  = res.temp_out_ch0;
  assign temp_out_ch1  = res.temp_out_ch1;
  assign power_out_ch0 = res.power_out_ch0;
  assign power_out_ch1 = res.power_out_ch1;
  assign acted         = res.acted;
  assign step_dir      = res.step_dir;

endmodule

@@ tb/tb_rotary_knob_setpoint_adjust.sv @@
`timescale 1ns / 1ps

module tb_rotary_knob_setpoint_adjust;
  import rksa_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAB_ROWS    = 24;

  localparam logic [2:0] MODE_OTHER = 3'd0;
  localparam logic [2:0] MODE_BAD5  = 3'd5;
  localparam logic [2:0] MODE_BAD7  = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } tab_row_t;

  localparam result_t NO_RES = '0;

  // item: {a b, mode, tch pch, tl0 tl1 pl0 pl1}
  // rows 0-1 run under reset config, the rest with limit 0, temp 84..86, power max 2
  localparam tab_row_t [0:TAB_ROWS-1] KNOB_TAB = {
    {{2'b11, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd84, 10'd84, 8'd0, 8'd0, 1'b0, DIR_HOLD}},
    {{2'b11, MODE_BAD7, 2'b11, 4'b1111}, 1'b1,
     {10'd84, 10'd84, 8'd0, 8'd0, 1'b0, DIR_HOLD}},
    {{2'b11, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd85, 10'd84, 8'd0, 8'd0, 1'b1, DIR_PLUS}},
    {{2'b10, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd85, 10'd84, 8'd0, 8'd0, 1'b1, DIR_HOLD}},
    {{2'b01, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b0, NO_RES},
    {{2'b01, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b0, NO_RES},
    // decrement at temp_min
    {{2'b10, MODE_TEMP_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd84, 10'd84, 8'd0, 8'd0, 1'b1, DIR_MINUS}},
    {{2'b00, MODE_TEMP_DUAL, 2'b10, 4'b0000}, 1'b0, NO_RES},
    {{2'b11, MODE_TEMP_DUAL, 2'b10, 4'b0000}, 1'b0, NO_RES},
    // increment at temp_max
    {{2'b00, MODE_TEMP_DUAL, 2'b10, 4'b0000}, 1'b1,
     {10'd84, 10'd86, 8'd0, 8'd0, 1'b1, DIR_PLUS}},
    // locked single temp
    {{2'b11, MODE_TEMP_SINGLE, 2'b00, 4'b1000}, 1'b1,
     {10'd84, 10'd86, 8'd0, 8'd0, 1'b1, DIR_HOLD}},
    {{2'b11, MODE_TEMP_DUAL, 2'b10, 4'b0100}, 1'b0, NO_RES},
    {{2'b11, MODE_TEMP_DUAL, 2'b00, 4'b0100}, 1'b0, NO_RES},
    // power decrement at zero
    {{2'b01, MODE_POWER_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd85, 10'd86, 8'd0, 8'd0, 1'b1, DIR_MINUS}},
    {{2'b11, MODE_POWER_SINGLE, 2'b00, 4'b0000}, 1'b0, NO_RES},
    {{2'b00, MODE_POWER_SINGLE, 2'b00, 4'b0000}, 1'b0, NO_RES},
    // power increment at power_max
    {{2'b11, MODE_POWER_SINGLE, 2'b00, 4'b0000}, 1'b1,
     {10'd85, 10'd86, 8'd2, 8'd0, 1'b1, DIR_PLUS}},
    {{2'b00, MODE_POWER_SINGLE, 2'b00, 4'b0010}, 1'b0, NO_RES},
    {{2'b00, MODE_POWER_DUAL, 2'b01, 4'b0000}, 1'b0, NO_RES},
    {{2'b10, MODE_POWER_DUAL, 2'b01, 4'b0001}, 1'b0, NO_RES},
    {{2'b10, MODE_POWER_DUAL, 2'b00, 4'b0001}, 1'b1,
     {10'd85, 10'd86, 8'd1, 8'd1, 1'b1, DIR_MINUS}},
    {{2'b01, MODE_OTHER, 2'b00, 4'b0000}, 1'b0, NO_RES},
    {{2'b01, MODE_BAD5, 2'b00, 4'b0000}, 1'b0, NO_RES},
    {{2'b01, MODE_BAD7, 2'b11, 4'b1111}, 1'b1,
     {10'd85, 10'd86, 8'd1, 8'd1, 1'b1, DIR_HOLD}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                a_level = 1'b0;
  logic                b_level = 1'b0;
  logic [2:0]          screen_mode = '0;
  logic                temp_channel = 1'b0;
  logic                power_channel = 1'b0;
  logic                temp_lock_ch0 = 1'b0;
  logic                temp_lock_ch1 = 1'b0;
  logic                power_lock_ch0 = 1'b0;
  logic                power_lock_ch1 = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TEMP_W-1:0]   temp_out_ch0;
  logic [TEMP_W-1:0]   temp_out_ch1;
  logic [POWER_W-1:0]  power_out_ch0;
  logic [POWER_W-1:0]  power_out_ch1;
  logic                acted;
  logic [1:0]          step_dir;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  rotary_knob_setpoint_adjust u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .a_level        (a_level),
    .b_level        (b_level),
    .screen_mode    (screen_mode),
    .temp_channel   (temp_channel),
    .power_channel  (power_channel),
    .temp_lock_ch0  (temp_lock_ch0),
    .temp_lock_ch1  (temp_lock_ch1),
    .power_lock_ch0 (power_lock_ch0),
    .power_lock_ch1 (power_lock_ch1),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .temp_out_ch0   (temp_out_ch0),
    .temp_out_ch1   (temp_out_ch1),
    .power_out_ch0  (power_out_ch0),
    .power_out_ch1  (power_out_ch1),
    .acted          (acted),
    .step_dir       (step_dir),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [LIMIT_W-1:0] lim_r;
  logic [TEMP_W-1:0]  tmin_r;
  logic [TEMP_W-1:0]  tmax_r;
  logic [POWER_W-1:0] pmax_r;
  logic [LIMIT_W-1:0] tick_cnt;
  logic               prev_a_r;
  logic [TEMP_W-1:0]  temp_r [2];
  logic [POWER_W-1:0] power_r [2];

  result_t setpoint_q [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // knob turning stimulus state
  int         run_left = 0;
  bit         run_up = 1'b0;
  logic [2:0] run_mode = MODE_TEMP_SINGLE;
  logic       run_tch = 1'b0;
  logic       run_pch = 1'b0;
  logic [1:0] quad_pos = 2'd0;

  function automatic result_t next_setpoints(input item_t it);
    result_t res;
    logic sel_t, sel_p, ch;
    logic [1:0] dir;
    sel_t = 1'b0;
    sel_p = 1'b0;
    ch = 1'b0;
    dir = DIR_HOLD;
    res.acted = 1'b0;
    if (tick_cnt < lim_r) begin
      tick_cnt = tick_cnt + 1'b1;
    end else begin
      tick_cnt = '0;
      res.acted = 1'b1;
      if (!it.temp_lock_ch0 && it.screen_mode == MODE_TEMP_SINGLE) begin
        sel_t = 1'b1;
      end else if (!it.temp_lock_ch0 && it.screen_mode == MODE_TEMP_DUAL && !it.temp_channel) begin
        sel_t = 1'b1;
      end else if (!it.temp_lock_ch1 && it.screen_mode == MODE_TEMP_DUAL && it.temp_channel) begin
        sel_t = 1'b1;
        ch = 1'b1;
      end else if (!it.power_lock_ch0 && it.screen_mode == MODE_POWER_SINGLE) begin
        sel_p = 1'b1;
      end else if (!it.power_lock_ch0 && it.screen_mode == MODE_POWER_DUAL
                   && !it.power_channel) begin
        sel_p = 1'b1;
      end else if (!it.power_lock_ch1 && it.screen_mode == MODE_POWER_DUAL
                   && it.power_channel) begin
        sel_p = 1'b1;
        ch = 1'b1;
      end
      if ((sel_t || sel_p) && it.a_level != prev_a_r) begin
        prev_a_r = it.a_level;
        dir = (it.b_level != it.a_level) ? DIR_MINUS : DIR_PLUS;
      end
      if (sel_t) begin
        if (dir == DIR_MINUS && temp_r[ch] > tmin_r) temp_r[ch] = temp_r[ch] - 1'b1;
        if (dir == DIR_PLUS && temp_r[ch] < tmax_r) temp_r[ch] = temp_r[ch] + 1'b1;
      end else if (sel_p) begin
        if (dir == DIR_MINUS && power_r[ch] > '0) power_r[ch] = power_r[ch] - 1'b1;
        if (dir == DIR_PLUS && power_r[ch] < pmax_r) power_r[ch] = power_r[ch] + 1'b1;
      end
    end
    res.temp_out_ch0  = temp_r[0];
    res.temp_out_ch1  = temp_r[1];
    res.power_out_ch0 = power_r[0];
    res.power_out_ch1 = power_r[1];
    res.step_dir      = dir;
    return res;
  endfunction

  // mostly quadrature runs in one direction, some raw noise
  function automatic item_t next_knob_item();
    item_t it;
    bit [31:0] r;
    bit [31:0] lk;
    r = $urandom;
    lk = $urandom;
    if (r[6:0] < 7'd19) begin
      it = r[26:16];
      return it;
    end
    if (run_left == 0) begin
      run_up = r[7];
      run_left = 1 + r[12:8];
      if (r[14:13] == 2'd0) begin
        run_mode = {1'b0, r[16:15]} + 3'd1;
        run_tch = r[17];
        run_pch = r[18];
      end
    end
    run_left--;
    if (r[21:19] != 3'd0) quad_pos = run_up ? quad_pos + 2'd1 : quad_pos - 2'd1;
    it.a_level        = quad_pos[1];
    it.b_level        = quad_pos[1] ^ quad_pos[0];
    it.screen_mode    = run_mode;
    it.temp_channel   = run_tch;
    it.power_channel  = run_pch;
    it.temp_lock_ch0  = (lk[3:0] == 4'd0);
    it.temp_lock_ch1  = (lk[7:4] == 4'd0);
    it.power_lock_ch0 = (lk[11:8] == 4'd0);
    it.power_lock_ch1 = (lk[15:12] == 4'd0);
    return it;
  endfunction

  task automatic set_idling(input idle_mode_e m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 84;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 84;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endtask

  task automatic drive_tick(input item_t it, input logic typed, input result_t typed_res);
    result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    a_level        <= it.a_level;
    b_level        <= it.b_level;
    screen_mode    <= it.screen_mode;
    temp_channel   <= it.temp_channel;
    power_channel  <= it.power_channel;
    temp_lock_ch0  <= it.temp_lock_ch0;
    temp_lock_ch1  <= it.temp_lock_ch1;
    power_lock_ch0 <= it.power_lock_ch0;
    power_lock_ch1 <= it.power_lock_ch1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = next_setpoints(it);
    setpoint_q.push_back(typed ? typed_res : pred);
  endtask

  task automatic walk_table(input int first, input int last);
    for (int i = first; i <= last; i++) begin
      drive_tick(KNOB_TAB[i].it, KNOB_TAB[i].typed, KNOB_TAB[i].res);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PRESCALE_LIMIT: lim_r = data;
      REG_TEMP_MIN:       tmin_r = data[TEMP_W-1:0];
      REG_TEMP_MAX:       tmax_r = data[TEMP_W-1:0];
      REG_POWER_MAX:      pmax_r = data[POWER_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits are junk and must be masked off
  task automatic load_config(input logic [LIMIT_W-1:0] lim, input logic [TEMP_W-1:0] lo,
                             input logic [TEMP_W-1:0] hi, input logic [POWER_W-1:0] pmax);
    bit [31:0] r;
    settle();
    r = $urandom;
    cfg_write(REG_PRESCALE_LIMIT, lim);
    cfg_write(REG_TEMP_MIN, {r[5:0], lo});
    cfg_write(REG_TEMP_MAX, {r[11:6], hi});
    cfg_write(REG_POWER_MAX, {r[19:12], pmax});
    cfg_write(IDX_W'($urandom_range(255, 4)), r[31:16]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input logic [TEMP_W-1:0] lo,
                           input logic [TEMP_W-1:0] hi, input logic [POWER_W-1:0] pmax,
                           input idle_mode_e m, input int n);
    load_config(lim, lo, hi, pmax);
    set_idling(m);
    repeat (n) drive_tick(next_knob_item(), 1'b0, NO_RES);
  endtask

  task automatic field_check(input string name, input int unsigned e, input int unsigned a);
    if (e != a) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (setpoint_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %0d %0d %0d %0d %0d %0d",
                   $time, temp_out_ch0, temp_out_ch1, power_out_ch0, power_out_ch1,
                   acted, step_dir);
          mismatches++;
        end else begin
          exp_r = setpoint_q.pop_front();
          field_check("temp_out_ch0", exp_r.temp_out_ch0, temp_out_ch0);
          field_check("temp_out_ch1", exp_r.temp_out_ch1, temp_out_ch1);
          field_check("power_out_ch0", exp_r.power_out_ch0, power_out_ch0);
          field_check("power_out_ch1", exp_r.power_out_ch1, power_out_ch1);
          field_check("acted", exp_r.acted, acted);
          field_check("step_dir", exp_r.step_dir, step_dir);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rotary_knob_setpoint_adjust verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit [31:0] r;
    lim_r      = RST_PRESCALE_LIMIT;
    tmin_r     = RST_TEMP_MIN;
    tmax_r     = RST_TEMP_MAX;
    pmax_r     = RST_POWER_MAX;
    tick_cnt   = '0;
    prev_a_r   = 1'b0;
    temp_r[0]  = RST_TEMP_SETTING;
    temp_r[1]  = RST_TEMP_SETTING;
    power_r[0] = '0;
    power_r[1] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_idling(IDLE_BOTH);
    walk_table(0, 1);
    load_config(16'd0, 10'd84, 10'd86, 8'd2);
    walk_table(2, TAB_ROWS - 1);

    run_phase(16'd0, 10'd0, 10'd1023, 8'd255, IDLE_NONE, 150);
    run_phase(16'd1, 10'd80, 10'd90, 8'd5, IDLE_SENDER, 150);
    run_phase(16'd0, 10'd100, 10'd95, 8'd0, IDLE_RECEIVER, 150);
    r = $urandom;
    run_phase({14'd0, r[1:0]}, r[11:2], r[21:12], r[29:22], IDLE_BOTH, 150);
    // counter runs up under a huge limit, then the limit drops below it
    run_phase(16'd65535, 10'd84, 10'd424, 8'd100, IDLE_NONE, 40);
    run_phase(16'd3, 10'd1023, 10'd0, 8'd255, IDLE_SENDER, 150);
    run_phase(RST_PRESCALE_LIMIT, RST_TEMP_MIN, RST_TEMP_MAX, RST_POWER_MAX,
              IDLE_RECEIVER, 420);
    r = $urandom;
    run_phase({14'd0, r[1:0]}, r[11:2], r[21:12], r[29:22], IDLE_BOTH, 150);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("rotary_knob_setpoint_adjust verification clean");
    end else begin
      $display("rotary_knob_setpoint_adjust verification failed");
    end
    $finish;
  end

endmodule
